// ===== rtl/tcw_pkg.sv =====
// Shared constants, command codes and control structs of the text console writer.
// Used by every module of the block but tcw_ram; depends on nothing.
package tcw_pkg;

  localparam int COLUMNS  = 80;
  localparam int ROWS     = 25;
  localparam int CELLS    = COLUMNS * ROWS;
  localparam int MOVE_CNT = CELLS - COLUMNS;
  localparam int COL_W    = $clog2(COLUMNS);
  localparam int ROW_W    = $clog2(ROWS);
  localparam int ADDR_W   = $clog2(CELLS);
  localparam int SWEEP_W  = $clog2(CELLS + 1);
  localparam int ENTRY_W  = 16;

  localparam logic [2:0] OP_PUT   = 3'd0;
  localparam logic [2:0] OP_SET   = 3'd1;
  localparam logic [2:0] OP_CLEAR = 3'd2;
  localparam logic [2:0] OP_READ  = 3'd3;
  localparam logic [2:0] OP_WRITE = 3'd4;

  localparam logic [7:0] CH_NEWLINE   = 8'd10;
  localparam logic [7:0] CH_BACKSPACE = 8'd8;
  localparam logic [7:0] CH_TAB       = 8'd9;
  localparam logic [7:0] CH_SPACE     = 8'd32;
  localparam int         TAB_STEP     = 8;
  localparam int         TAB_MASK     = TAB_STEP - 1;

  localparam logic [7:0] TEXT_COLOR_RESET = 8'd2;

  typedef struct packed {
    logic exec;
    logic issue_read;
    logic sweep_start;
    logic sweep_step;
    logic emit;
  } ctl_cmd_t;

  typedef struct packed {
    logic cmd_valid;
    logic out_free;
    logic need_read;
    logic need_sweep;
    logic sweep_done;
  } ctl_stat_t;

  function automatic logic [ADDR_W-1:0] cell_addr(input int r, input int c);
    return ADDR_W'(r * COLUMNS + c);
  endfunction

endpackage

// ===== rtl/text_console_writer.sv =====
// Text console writer: 80x25 cell store with cursor, put-char, cursor, clear and cell access.
// Most words produce their result straight from execute; an in-range cell read goes through the
// registered store read first, and clear and a put-char that scrolls run a sweep over every cell.
// Throughput: one word per cycle while the output is not stalled; a read or a sweep stalls input.
// Reset clears cursor to home and text color to 2; the cell store is undefined until cleared.
// Depends on tcw_pkg, tcw_ctrl, tcw_dp and tcw_ram.
module text_console_writer (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [7:0]                cfg_wdata,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [2:0]                in_op,
  input  logic [7:0]                in_char_code,
  input  logic [7:0]                in_cell_color,
  input  logic [7:0]                in_col,
  input  logic [7:0]                in_row,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [tcw_pkg::COL_W-1:0] out_cursor_col,
  output logic [tcw_pkg::ROW_W-1:0] out_cursor_row,
  output logic [7:0]                out_read_char,
  output logic [7:0]                out_read_color,
  output logic                      out_at_bottom
);

  tcw_pkg::ctl_cmd_t  cmd;
  tcw_pkg::ctl_stat_t stat;

  tcw_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .cmd   (cmd)
  );

  tcw_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_op          (in_op),
    .in_char_code   (in_char_code),
    .in_cell_color  (in_cell_color),
    .in_col         (in_col),
    .in_row         (in_row),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_cursor_col (out_cursor_col),
    .out_cursor_row (out_cursor_row),
    .out_read_char  (out_read_char),
    .out_read_color (out_read_color),
    .out_at_bottom  (out_at_bottom),
    .cmd            (cmd),
    .stat           (stat)
  );

  a_emit_into_free_slot : assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.emit && out_valid && out_stall))
    else $error("result word overwrote a stalled result");

  a_emit_needs_command : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> stat.cmd_valid)
    else $error("result word without a pending command");

  a_cursor_in_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (int'(out_cursor_col) < tcw_pkg::COLUMNS)
                  && (int'(out_cursor_row) < tcw_pkg::ROWS))
    else $error("cursor out of screen");

  a_sweep_blocks_input : assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.sweep_step && !cmd.emit) |-> in_stall)
    else $error("input taken during store sweep");

endmodule

// ===== rtl/tcw_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/tcw_ctrl.sv =====
// Controller of the text console writer: sequences execute, cell read and store sweeps.
// Depends on tcw_pkg for the command and status structs.
module tcw_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  tcw_pkg::ctl_stat_t stat,
  output tcw_pkg::ctl_cmd_t  cmd
);

  typedef enum logic [1:0] {S_RUN, S_READ, S_SWEEP} state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_RUN: begin
        if (stat.cmd_valid && stat.out_free) begin
          cmd.exec = 1'b1;
          priority if (stat.need_read) begin
            cmd.issue_read = 1'b1;
            state_nxt      = S_READ;
          end else if (stat.need_sweep) begin
            cmd.sweep_start = 1'b1;
            state_nxt       = S_SWEEP;
          end else begin
            cmd.emit = 1'b1;
          end
        end
      end
      S_READ: begin
        cmd.emit  = 1'b1;
        state_nxt = S_RUN;
      end
      S_SWEEP: begin
        cmd.sweep_step = 1'b1;
        if (stat.sweep_done) begin
          cmd.emit  = 1'b1;
          state_nxt = S_RUN;
        end
      end
      default: state_nxt = S_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_RUN;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/tcw_dp.sv =====
// Datapath of the text console writer: command word, cursor, color, cell store, result word.
// Depends on tcw_pkg and tcw_ram.
module tcw_dp (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [7:0]                cfg_wdata,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [2:0]                in_op,
  input  logic [7:0]                in_char_code,
  input  logic [7:0]                in_cell_color,
  input  logic [7:0]                in_col,
  input  logic [7:0]                in_row,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [tcw_pkg::COL_W-1:0] out_cursor_col,
  output logic [tcw_pkg::ROW_W-1:0] out_cursor_row,
  output logic [7:0]                out_read_char,
  output logic [7:0]                out_read_color,
  output logic                      out_at_bottom,
  input  tcw_pkg::ctl_cmd_t         cmd,
  output tcw_pkg::ctl_stat_t        stat
);

  localparam int CW = tcw_pkg::COL_W;
  localparam int RW = tcw_pkg::ROW_W;
  localparam int AW = tcw_pkg::ADDR_W;
  localparam int EW = tcw_pkg::ENTRY_W;
  localparam int SW = tcw_pkg::SWEEP_W;

  logic          cmd_valid_r;
  logic [2:0]    cmd_op_r;
  logic [7:0]    cmd_char_r;
  logic [7:0]    cmd_color_r;
  logic [7:0]    cmd_col_r;
  logic [7:0]    cmd_row_r;
  logic [CW-1:0] cur_col_r;
  logic [RW-1:0] cur_row_r;
  logic [CW-1:0] cur_col_nxt;
  logic [RW-1:0] cur_row_nxt;
  logic [CW-1:0] col_exec;
  logic [RW-1:0] row_exec;
  logic [7:0]    text_color_r;
  logic [SW-1:0] sweep_r;

  logic          out_valid_r;
  logic [CW-1:0] out_col_r;
  logic [RW-1:0] out_row_r;
  logic [7:0]    out_char_r;
  logic [7:0]    out_color_r;
  logic          out_bottom_r;

  logic          in_rng;
  logic          newline;
  logic          last_row;
  logic          need_scroll;
  logic          wr_exec;
  logic [AW-1:0] waddr_exec;
  logic [EW-1:0] wdata_exec;
  logic          rd_hit;
  logic          scroll_sweep;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [EW-1:0] ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [EW-1:0] ram_rdata;

  assign in_rng   = (int'(cmd_col_r) < tcw_pkg::COLUMNS) && (int'(cmd_row_r) < tcw_pkg::ROWS);
  assign last_row = (int'(cur_row_r) == tcw_pkg::ROWS - 1);
  assign rd_hit   = (cmd_op_r == tcw_pkg::OP_READ) && in_rng;

  always_comb begin
    logic [CW:0]   c_inc;
    logic [CW:0]   c_tab;
    logic [CW-1:0] bs_col;
    logic [RW-1:0] bs_row;
    c_inc       = {1'b0, cur_col_r} + (CW+1)'(1);
    c_tab       = ({1'b0, cur_col_r} + (CW+1)'(tcw_pkg::TAB_STEP))
                  & ~(CW+1)'(tcw_pkg::TAB_MASK);
    bs_col      = cur_col_r;
    bs_row      = cur_row_r;
    col_exec    = cur_col_r;
    row_exec    = cur_row_r;
    newline     = 1'b0;
    wr_exec     = 1'b0;
    waddr_exec  = tcw_pkg::cell_addr(int'(cur_row_r), int'(cur_col_r));
    wdata_exec  = {text_color_r, cmd_char_r};
    unique case (cmd_op_r)
      tcw_pkg::OP_PUT: begin
        priority if (cmd_char_r == tcw_pkg::CH_NEWLINE) begin
          newline = 1'b1;
        end else if (cmd_char_r == tcw_pkg::CH_BACKSPACE) begin
          if (cur_col_r != '0) begin
            bs_col = cur_col_r - CW'(1);
          end else if (cur_row_r != '0) begin
            bs_row = cur_row_r - RW'(1);
            bs_col = CW'(tcw_pkg::COLUMNS - 1);
          end
          col_exec    = bs_col;
          row_exec    = bs_row;
          wr_exec     = 1'b1;
          waddr_exec  = tcw_pkg::cell_addr(int'(bs_row), int'(bs_col));
          wdata_exec  = {text_color_r, tcw_pkg::CH_SPACE};
        end else if (cmd_char_r == tcw_pkg::CH_TAB) begin
          if (int'(c_tab) >= tcw_pkg::COLUMNS) begin
            newline = 1'b1;
          end else begin
            col_exec = c_tab[CW-1:0];
          end
        end else begin
          wr_exec = 1'b1;
          if (int'(c_inc) >= tcw_pkg::COLUMNS) begin
            newline = 1'b1;
          end else begin
            col_exec = c_inc[CW-1:0];
          end
        end
      end
      tcw_pkg::OP_SET: begin
        col_exec = (int'(cmd_col_r) >= tcw_pkg::COLUMNS) ? CW'(tcw_pkg::COLUMNS - 1)
                                                          : CW'(cmd_col_r);
        row_exec = (int'(cmd_row_r) >= tcw_pkg::ROWS) ? RW'(tcw_pkg::ROWS - 1)
                                                       : RW'(cmd_row_r);
      end
      tcw_pkg::OP_CLEAR: begin
        col_exec = '0;
        row_exec = '0;
      end
      tcw_pkg::OP_WRITE: begin
        wr_exec    = in_rng;
        waddr_exec = tcw_pkg::cell_addr(int'(cmd_row_r), int'(cmd_col_r));
        wdata_exec = {cmd_color_r, cmd_char_r};
      end
      default: ;
    endcase
    if (newline) begin
      col_exec = '0;
      row_exec = last_row ? cur_row_r : cur_row_r + RW'(1);
    end
  end

  assign cur_col_nxt = cmd.exec ? col_exec : cur_col_r;
  assign cur_row_nxt = cmd.exec ? row_exec : cur_row_r;

  assign need_scroll  = (cmd_op_r == tcw_pkg::OP_PUT) && newline && last_row;
  assign scroll_sweep = (cmd_op_r != tcw_pkg::OP_CLEAR);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = waddr_exec;
    ram_wdata = wdata_exec;
    ram_re    = 1'b0;
    ram_raddr = tcw_pkg::cell_addr(int'(cmd_row_r), int'(cmd_col_r));
    if (cmd.sweep_step) begin
      ram_we    = (sweep_r != '0);
      ram_waddr = AW'(int'(sweep_r) - 1);
      ram_re    = scroll_sweep && (int'(sweep_r) < tcw_pkg::MOVE_CNT);
      ram_raddr = AW'(int'(sweep_r) + tcw_pkg::COLUMNS);
      if (!scroll_sweep) begin
        ram_wdata = {cmd_color_r, tcw_pkg::CH_SPACE};
      end else if (int'(sweep_r) - 1 < tcw_pkg::MOVE_CNT) begin
        ram_wdata = ram_rdata;
      end else begin
        ram_wdata = {text_color_r, tcw_pkg::CH_SPACE};
      end
    end else begin
      ram_we = cmd.exec && wr_exec;
      ram_re = cmd.issue_read;
    end
  end

  tcw_ram #(
    .WIDTH (EW),
    .DEPTH (tcw_pkg::CELLS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_stall = cmd_valid_r && !cmd.emit;

  assign stat.cmd_valid  = cmd_valid_r;
  assign stat.out_free   = !out_valid_r || !out_stall;
  assign stat.need_read  = rd_hit;
  assign stat.need_sweep = (cmd_op_r == tcw_pkg::OP_CLEAR) || need_scroll;
  assign stat.sweep_done = (int'(sweep_r) == tcw_pkg::CELLS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_valid_r  <= 1'b0;
      cur_col_r    <= '0;
      cur_row_r    <= '0;
      text_color_r <= tcw_pkg::TEXT_COLOR_RESET;
      out_valid_r  <= 1'b0;
      sweep_r      <= '0;
    end else begin
      if (in_valid && !in_stall) begin
        cmd_valid_r <= 1'b1;
      end else if (cmd.emit) begin
        cmd_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        text_color_r <= cfg_wdata;
      end
      cur_col_r <= cur_col_nxt;
      cur_row_r <= cur_row_nxt;
      if (cmd.sweep_start) begin
        sweep_r <= '0;
      end else if (cmd.sweep_step) begin
        sweep_r <= sweep_r + SW'(1);
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      cmd_op_r    <= in_op;
      cmd_char_r  <= in_char_code;
      cmd_color_r <= in_cell_color;
      cmd_col_r   <= in_col;
      cmd_row_r   <= in_row;
    end
    if (cmd.emit) begin
      out_col_r    <= cur_col_nxt;
      out_row_r    <= cur_row_nxt;
      out_char_r   <= rd_hit ? ram_rdata[7:0] : 8'd0;
      out_color_r  <= rd_hit ? ram_rdata[15:8] : 8'd0;
      out_bottom_r <= (int'(cur_row_nxt) == tcw_pkg::ROWS - 1);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_cursor_col = out_col_r;
  assign out_cursor_row = out_row_r;
  assign out_read_char  = out_char_r;
  assign out_read_color = out_color_r;
  assign out_at_bottom  = out_bottom_r;

endmodule
